FILE: hdl/tsl_pkg.sv
// Shared types and constants for the three-axis shift low-pass filter.
package tsl_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int SHIFT_W       = 4;
  localparam int FRAC_BITS_DEF = 8;
  localparam int NUM_AXES      = 3;
  localparam int NUM_CH        = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd3;

  // register index, taken from paddr[2]
  localparam logic REG_GYRO_SHIFT = 1'b0;
  localparam logic REG_MAG_SHIFT  = 1'b1;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic CH_GYRO = 1'b0;
  localparam logic CH_MAG  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef struct packed {
    logic                       operation;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
  } in_req_t;

  typedef struct packed {
    logic                       status;
    logic signed [SAMPLE_W-1:0] filtered_x;
    logic signed [SAMPLE_W-1:0] filtered_y;
    logic signed [SAMPLE_W-1:0] filtered_z;
  } out_res_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] gyro;
    logic [SHIFT_W-1:0] mag;
  } shift_cfg_t;

endpackage

FILE: hdl/three_axis_shift_lowpass.sv
// Top level of the three-axis shift low-pass filter: request/result pipeline.
//
// Use:
//   Requests enter on in_valid/in_data and are taken at an edge with in_valid
//   high and in_stall low. A request either filters one three-axis sample on
//   the gyro or magnetometer channel, or clears that channel's state.
//   Every request yields exactly one result on out_valid/out_data, in order.
//   The accepting edge loads the input register; the result register loads
//   once empty or being taken, raising out_valid. Throughput: one request
//   per cycle while out_stall is low; the accumulator update for all three
//   axes is one subtract, one shift and one add between the input register
//   and the result register, so same-channel requests may follow directly.
//   Stall: a waiting result holds in the result register; one more request
//   is still taken into the input register, after which in_stall rises until
//   the receiver takes the result.
//   Reset (rst_n low, synchronous): both channels unprimed, both shifts 3,
//   pipeline empty. Shifts are written over the cfg_ APB port, gyro at byte
//   address 0, magnetometer at 4, only while idle: a user rule, not enforced.
module three_axis_shift_lowpass
  import tsl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_res_t              out_data,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  shift_cfg_t shifts;

  logic       s1_valid_r, s1_valid_nxt;
  in_req_t    s1_req_r;
  logic       out_valid_r, out_valid_nxt;
  out_res_t   out_data_r;
  out_res_t   core_res;
  logic       advance;
  logic       in_take;

  tsl_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .shifts     (shifts)
  );

  // request moves from the input register into the result register
  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  tsl_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .req   (s1_req_r),
    .shifts(shifts),
    .res   (core_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_data;
    end
    if (advance) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/tsl_regs.sv
// APB-style configuration registers holding the per-channel smoothing shifts.
module tsl_regs
  import tsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output shift_cfg_t            shifts
);

  logic [SHIFT_W-1:0] gyro_shift_r, gyro_shift_nxt;
  logic [SHIFT_W-1:0] mag_shift_r, mag_shift_nxt;
  logic               wr_en;
  logic               reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[2];

  always_comb begin
    gyro_shift_nxt = gyro_shift_r;
    mag_shift_nxt  = mag_shift_r;
    if (wr_en) begin
      case (reg_idx)
        REG_GYRO_SHIFT: gyro_shift_nxt = cfg_pwdata[SHIFT_W-1:0];
        REG_MAG_SHIFT:  mag_shift_nxt  = cfg_pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_shift_r <= SHIFT_RESET;
      mag_shift_r  <= SHIFT_RESET;
    end else begin
      gyro_shift_r <= gyro_shift_nxt;
      mag_shift_r  <= mag_shift_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GYRO_SHIFT: cfg_prdata = {{(CFG_DATA_W-SHIFT_W){1'b0}}, gyro_shift_r};
      REG_MAG_SHIFT:  cfg_prdata = {{(CFG_DATA_W-SHIFT_W){1'b0}}, mag_shift_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign shifts.gyro = gyro_shift_r;
  assign shifts.mag  = mag_shift_r;

endmodule

FILE: hdl/tsl_core.sv
// Per-channel accumulators, primed flags and the single-pass filter datapath.
module tsl_core
  import tsl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  in_req_t    req,
  input  shift_cfg_t shifts,
  output out_res_t   res
);

  localparam int ACC_W = SAMPLE_W + FRAC_BITS + 1;

  logic signed [ACC_W-1:0]    acc_r [NUM_CH][NUM_AXES];
  logic [NUM_CH-1:0]          primed_r;

  logic signed [SAMPLE_W-1:0] smp     [NUM_AXES];
  logic signed [ACC_W-1:0]    scaled  [NUM_AXES];
  logic signed [ACC_W-1:0]    acc_new [NUM_AXES];
  logic signed [SAMPLE_W-1:0] filt    [NUM_AXES];
  logic [SHIFT_W-1:0]         shift;
  logic                       all_zero;
  logic                       all_ones;
  logic                       rejected;
  logic                       is_clear;
  logic                       primed;

  assign smp[0] = req.sample_x;
  assign smp[1] = req.sample_y;
  assign smp[2] = req.sample_z;

  assign shift = (req.channel == CH_MAG) ? shifts.mag : shifts.gyro;

  genvar a;
  generate
    for (a = 0; a < NUM_AXES; a++) begin : g_axis
      logic signed [ACC_W-1:0] acc_cur;
      logic signed [ACC_W:0]   diff;
      logic signed [ACC_W:0]   step;
      logic signed [ACC_W-1:0] acc_q;

      assign acc_cur    = acc_r[req.channel][a];
      assign scaled[a]  = ACC_W'(smp[a]) <<< FRAC_BITS;
      assign diff       = (ACC_W+1)'(scaled[a]) - (ACC_W+1)'(acc_cur);
      assign step       = diff >>> shift;
      assign acc_new[a] = acc_cur + step[ACC_W-1:0];
      assign acc_q      = acc_new[a] >>> FRAC_BITS;
      assign filt[a]    = acc_q[SAMPLE_W-1:0];
    end
  endgenerate

  assign all_zero = (smp[0] == '0) && (smp[1] == '0) && (smp[2] == '0);
  assign all_ones = (smp[0] == '1) && (smp[1] == '1) && (smp[2] == '1);
  assign rejected = all_zero | all_ones;
  assign is_clear = (req.operation == OP_CLEAR);
  assign primed   = primed_r[req.channel];

  always_comb begin
    res = '0;
    if (is_clear) begin
      res.status = STATUS_OK;
    end else if (rejected) begin
      res.status = STATUS_REJECTED;
    end else if (!primed) begin
      res.filtered_x = smp[0];
      res.filtered_y = smp[1];
      res.filtered_z = smp[2];
    end else begin
      res.filtered_x = filt[0];
      res.filtered_y = filt[1];
      res.filtered_z = filt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= '0;
    end else if (fire) begin
      if (is_clear) begin
        primed_r[req.channel] <= 1'b0;
      end else if (!rejected) begin
        primed_r[req.channel] <= 1'b1;
      end
    end
  end

  // accumulators are only read once primed, so they need no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (is_clear) begin
          acc_r[req.channel][i] <= '0;
        end else if (!rejected) begin
          acc_r[req.channel][i] <= primed ? acc_new[i] : scaled[i];
        end
      end
    end
  end

endmodule

FILE: hdl/tsl_checker.sv
// Port-level assertions for the three-axis shift low-pass filter, with bind.
module tsl_checker
  import tsl_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_res_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // rejected frames carry zero filtered axes
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_REJECTED) |->
      (out_data.filtered_x == '0) && (out_data.filtered_y == '0) &&
      (out_data.filtered_z == '0))
    else $error("rejected frame with nonzero axes");

  // input is only held off by a backed-up result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a waiting result");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind three_axis_shift_lowpass tsl_checker u_tsl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

FILE: tb/three_axis_shift_lowpass_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for three_axis_shift_lowpass: predictor, checker, stimulus.
module three_axis_shift_lowpass_tb;
  import tsl_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 185;

  // one row of the directed table: either a shift write or a request,
  // the latter with an optional hand-typed expected result
  typedef struct packed {
    bit                 is_cfg;
    logic               cfg_idx;
    logic [SHIFT_W-1:0] cfg_val;
    in_req_t            req;
    bit                 typed;
    out_res_t           exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // predictor state: Q8 accumulators, primed flags and shifts per channel
  logic signed [24:0] ema_acc [NUM_CH][NUM_AXES];
  logic               ch_primed [NUM_CH];
  logic [SHIFT_W-1:0] ch_shift [NUM_CH];

  out_res_t expected_results [$];
  int       bad_results = 0;
  int       cycles = 0;
  int       stall_left = 0;
  bit       in_quiet = 1'b0;
  bit       out_quiet = 1'b0;
  int       drift_base [NUM_CH][NUM_AXES];
  dir_row_t dir_rows [$];

  three_axis_shift_lowpass dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the pipeline hangs or a result never shows up.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Expected result of one accepted request; updates the predictor state.
  function automatic out_res_t predict_filter(in_req_t r);
    out_res_t           res;
    logic               ch;
    logic [SHIFT_W-1:0] k;
    logic signed [15:0] s [NUM_AXES];
    logic signed [15:0] f [NUM_AXES];
    int                 acc_v;
    int                 diff;
    res = '0;
    ch = r.channel;
    k = ch_shift[ch];
    s[0] = r.sample_x;
    s[1] = r.sample_y;
    s[2] = r.sample_z;
    f[0] = '0;
    f[1] = '0;
    f[2] = '0;
    if (r.operation == OP_CLEAR) begin
      // clear: channel back to unprimed, samples ignored
      for (int i = 0; i < NUM_AXES; i++) ema_acc[ch][i] = '0;
      ch_primed[ch] = 1'b0;
      return res;
    end
    // all-zero or all-minus-one frames are rejected, state untouched
    if ((s[0] == 0 && s[1] == 0 && s[2] == 0) ||
        (s[0] == -1 && s[1] == -1 && s[2] == -1)) begin
      res.status = STATUS_REJECTED;
      return res;
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      if (!ch_primed[ch]) begin
        // first good frame loads the accumulator and is echoed
        acc_v = int'(s[i]) * (1 << FRAC);
      end else begin
        acc_v = ema_acc[ch][i];
        diff = int'(s[i]) * (1 << FRAC) - acc_v;
        acc_v = acc_v + (diff >>> k);
      end
      ema_acc[ch][i] = acc_v[24:0];
      f[i] = 16'(acc_v >>> FRAC);
    end
    ch_primed[ch] = 1'b1;
    res.filtered_x = f[0];
    res.filtered_y = f[1];
    res.filtered_z = f[2];
    return res;
  endfunction

  function automatic dir_row_t req_row(logic op, logic ch, shortint x, shortint y,
                                       shortint z);
    dir_row_t row;
    row = '0;
    row.req = '{op, ch, x, y, z};
    return row;
  endfunction

  function automatic dir_row_t typed_row(logic op, logic ch, shortint x, shortint y,
                                         shortint z, logic st, shortint fx,
                                         shortint fy, shortint fz);
    dir_row_t row;
    row = req_row(op, ch, x, y, z);
    row.typed = 1'b1;
    row.exp = '{st, fx, fy, fz};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic idx, logic [SHIFT_W-1:0] v);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = v;
    return row;
  endfunction

  // Random request. Most traffic is well-formed sensor data drifting around a
  // per-channel level, so the filter is seen tracking; the rest is clears,
  // rejected frames, rail values and raw noise.
  function automatic in_req_t rand_req();
    in_req_t r;
    int      pick;
    int      v [NUM_AXES];
    logic    ch;
    ch = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    for (int i = 0; i < NUM_AXES; i++) begin
      if (pick < 14) begin
        case ($urandom_range(0, 4))
          0: v[i] = -32768;
          1: v[i] = 32767;
          2: v[i] = 0;
          3: v[i] = -1;
          default: v[i] = 1;
        endcase
      end else if (pick < 30) begin
        v[i] = int'(shortint'($urandom));
      end else begin
        if ($urandom_range(0, 49) == 0) drift_base[ch][i] = int'(shortint'($urandom));
        v[i] = drift_base[ch][i] + $urandom_range(0, 512) - 256;
        if (v[i] > 32767) v[i] = 32767;
        if (v[i] < -32768) v[i] = -32768;
      end
    end
    if (pick >= 4 && pick < 8) begin
      // rejected frame: all zero or all minus one
      for (int i = 0; i < NUM_AXES; i++) v[i] = ($urandom_range(0, 1) == 0) ? 0 : -1;
      v[1] = v[0];
      v[2] = v[0];
    end
    r.operation = (pick < 4) ? OP_CLEAR : OP_FILTER;
    r.channel = ch;
    r.sample_x = 16'(v[0]);
    r.sample_y = 16'(v[1]);
    r.sample_z = 16'(v[2]);
    return r;
  endfunction

  // Offer one request after a random gap, hold it until taken, then log
  // the expected result. Returns at the accepting edge with in_valid still up.
  task automatic send_req(in_req_t r, bit typed, out_res_t exp);
    int       gap;
    out_res_t res;
    gap = (in_quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    res = predict_filter(r);
    expected_results.push_back(typed ? exp : res);
  endtask

  task automatic wait_drain();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Shift write over APB once the pipeline is empty, then read it back.
  task automatic cfg_write(logic idx, logic [SHIFT_W-1:0] v);
    in_valid <= 1'b0;
    wait_drain();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    ch_shift[idx] = v;
    // read back: setup, access, sample in the access phase
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== CFG_DATA_W'(v)) begin
      $display("%0t: shift register %0d readback expected %0d got %0d",
               $time, idx, v, cfg_prdata);
      bad_results++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_result(out_res_t got);
    out_res_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result expected none got %h", $time, got);
      bad_results++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      bad_results++;
    end
    if (got.filtered_x !== want.filtered_x) begin
      $display("%0t: filtered_x expected %0d got %0d", $time, want.filtered_x,
               got.filtered_x);
      bad_results++;
    end
    if (got.filtered_y !== want.filtered_y) begin
      $display("%0t: filtered_y expected %0d got %0d", $time, want.filtered_y,
               got.filtered_y);
      bad_results++;
    end
    if (got.filtered_z !== want.filtered_z) begin
      $display("%0t: filtered_z expected %0d got %0d", $time, want.filtered_z,
               got.filtered_z);
      bad_results++;
    end
  endtask

  // Result side: check every taken result, then draw a random stall, possibly
  // none, before taking the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        stall_left = (out_quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    logic [SHIFT_W-1:0] g_shift;
    logic [SHIFT_W-1:0] m_shift;
    for (int c = 0; c < NUM_CH; c++) begin
      ch_shift[c] = SHIFT_RESET;
      ch_primed[c] = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        ema_acc[c][i] = '0;
        drift_base[c][i] = int'(shortint'($urandom));
      end
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, shifts at reset value 3 until rewritten.
    dir_rows = '{
      typed_row(OP_FILTER, CH_GYRO, 0, 0, 0, STATUS_REJECTED, 0, 0, 0),
      typed_row(OP_FILTER, CH_GYRO, -1, -1, -1, STATUS_REJECTED, 0, 0, 0),
      typed_row(OP_FILTER, CH_GYRO, 32767, -32768, 1, STATUS_OK, 32767, -32768, 1),
      req_row(OP_FILTER, CH_GYRO, -32768, 32767, -1),
      req_row(OP_FILTER, CH_GYRO, 0, 0, -1),
      // rejected on a primed channel must not disturb the accumulators
      typed_row(OP_FILTER, CH_GYRO, 0, 0, 0, STATUS_REJECTED, 0, 0, 0),
      typed_row(OP_CLEAR, CH_GYRO, 16'h1234, -1, -32768, STATUS_OK, 0, 0, 0),
      typed_row(OP_FILTER, CH_GYRO, -1, -1, 0, STATUS_OK, -1, -1, 0),
      typed_row(OP_FILTER, CH_MAG, -1, -1, -1, STATUS_REJECTED, 0, 0, 0),
      typed_row(OP_FILTER, CH_MAG, -32768, -32768, -32768, STATUS_OK,
                -32768, -32768, -32768),
      req_row(OP_FILTER, CH_MAG, 32767, 32767, 32767),
      typed_row(OP_CLEAR, CH_MAG, 32767, 32767, 32767, STATUS_OK, 0, 0, 0),
      typed_row(OP_CLEAR, CH_MAG, 5, 6, 7, STATUS_OK, 0, 0, 0),
      typed_row(OP_FILTER, CH_MAG, 1, -1, 0, STATUS_OK, 1, -1, 0),
      // shift zero: accumulator takes the new sample exactly
      cfg_row(REG_GYRO_SHIFT, 4'd0),
      typed_row(OP_FILTER, CH_GYRO, 12345, -12345, 32767, STATUS_OK, 12345, -12345, 32767),
      typed_row(OP_FILTER, CH_GYRO, -32768, 32767, 0, STATUS_OK, -32768, 32767, 0),
      // slowest filter, full-scale steps in both directions
      cfg_row(REG_MAG_SHIFT, 4'd15),
      req_row(OP_FILTER, CH_MAG, -32768, 32767, -32768),
      req_row(OP_FILTER, CH_MAG, 32767, -32768, 100),
      cfg_row(REG_GYRO_SHIFT, 4'd15),
      req_row(OP_FILTER, CH_GYRO, 32767, 32767, 32767),
      cfg_row(REG_MAG_SHIFT, 4'd0),
      typed_row(OP_FILTER, CH_MAG, 7, -7, 0, STATUS_OK, 7, -7, 0),
      // a clear is never rejected, whatever its sample fields
      typed_row(OP_CLEAR, CH_GYRO, 0, 0, 0, STATUS_OK, 0, 0, 0),
      typed_row(OP_CLEAR, CH_MAG, -1, -1, -1, STATUS_OK, 0, 0, 0)
    };
    foreach (dir_rows[n]) begin
      if (dir_rows[n].is_cfg) begin
        cfg_write(dir_rows[n].cfg_idx, dir_rows[n].cfg_val);
      end else begin
        send_req(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].exp);
      end
    end

    // Random part: one shift setting per phase, extremes first.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin g_shift = 4'd0;  m_shift = 4'd15; end
        1: begin g_shift = 4'd15; m_shift = 4'd0;  end
        2: begin g_shift = 4'd0;  m_shift = 4'd0;  end
        3: begin g_shift = 4'd15; m_shift = 4'd15; end
        default: begin
          g_shift = SHIFT_W'($urandom_range(0, 15));
          m_shift = SHIFT_W'($urandom_range(0, 15));
        end
      endcase
      cfg_write(REG_GYRO_SHIFT, g_shift);
      cfg_write(REG_MAG_SHIFT, m_shift);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 60 == 0) begin
          // mix stretches of back-to-back traffic with gappy traffic, on both sides
          in_quiet = ($urandom_range(0, 3) == 0);
          out_quiet = ($urandom_range(0, 3) == 0);
        end
        send_req(rand_req(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drain();
    repeat (10) @(posedge clk);
    if (bad_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
